// ===== rtl/core/vna_pkg.sv =====
// package: shared widths, opcodes, status codes and request/result types
package vna_pkg;

  localparam int MaxVerts = 1024;
  localparam int IdxW = 10;
  localparam int PosW = 16;
  localparam int SumW = 48;
  localparam int NormW = 16;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNLOAD = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IdxW-1:0]        vertex_index;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic [IdxW-1:0]        corner_a;
    logic [IdxW-1:0]        corner_b;
    logic [IdxW-1:0]        corner_c;
  } req_t;

  typedef struct packed {
    logic signed [NormW-1:0] norm_x;
    logic signed [NormW-1:0] norm_y;
    logic signed [NormW-1:0] norm_z;
    logic [1:0]              status;
  } res_t;

endpackage

// ===== rtl/core/vna_if.sv =====
// valid/ready stream interface carrying one payload struct
interface vna_req_if;
  import vna_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vna_res_if;
  import vna_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vna_norm.sv =====
// normalizer: scale three 48-bit sums to a Q1.14 unit vector, bit-serial search
module vna_norm
  import vna_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SumW-1:0]  sx,
  input  logic signed [SumW-1:0]  sy,
  input  logic signed [SumW-1:0]  sz,
  output logic                    done,
  output logic                    zero,
  output logic signed [NormW-1:0] qx,
  output logic signed [NormW-1:0] qy,
  output logic signed [NormW-1:0] qz
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_LIM   = 3'd3;
  localparam logic [2:0] N_SQT   = 3'd4;
  localparam logic [2:0] N_CMP   = 3'd5;
  localparam logic [2:0] N_DONE  = 3'd6;

  logic [2:0]  state;
  logic [SumW-1:0] mag [3];
  logic [2:0]  sgn;
  logic [1:0]  comp;
  logic [3:0]  bitpos;
  logic [14:0] q;
  logic [33:0] ssum;
  logic [61:0] lim;
  logic [31:0] tt;
  logic [14:0] qres [3];

  logic [SumW-1:0] mx;
  logic [14:0] trial;
  logic [15:0] t;
  logic [15:0] sq_in;
  logic [31:0] sq;
  logic [65:0] lhs;
  logic        fit;

  // one shared squarer, then the product compare of the search step
  always_comb begin
    mx = mag[0] | mag[1] | mag[2];
    trial = q | (15'd1 << bitpos);
    t = {trial, 1'b0} - 16'd1;
    sq_in = (state == N_SQT) ? t : mag[comp][15:0];
    sq = 32'(sq_in) * 32'(sq_in);
    lhs = 66'(tt) * 66'(ssum);
    fit = (trial <= 15'd16384) && (lhs <= 66'(lim));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            mag[0] <= sx[SumW-1] ? SumW'(-sx) : sx;
            mag[1] <= sy[SumW-1] ? SumW'(-sy) : sy;
            mag[2] <= sz[SumW-1] ? SumW'(-sz) : sz;
            sgn <= {sz[SumW-1], sy[SumW-1], sx[SumW-1]};
            state <= N_SHIFT;
          end
        end
        // shift all magnitudes right until the or-ed max fits 16 bits
        N_SHIFT: begin
          if (mx == '0) begin
            zero <= 1'b1;
            qx <= '0; qy <= '0; qz <= '0;
            done <= 1'b1;
            state <= N_IDLE;
          end else if (mx[SumW-1:16] != '0) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else begin
            zero <= 1'b0;
            ssum <= '0;
            comp <= 2'd0;
            state <= N_SQ;
          end
        end
        // accumulate squares one component a cycle
        N_SQ: begin
          ssum <= ssum + 34'(sq);
          if (comp == 2'd2) begin
            comp <= 2'd0;
            state <= N_LIM;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        // limit m^2*2^30 for the current component
        N_LIM: begin
          lim <= {sq, 30'd0};
          q <= '0;
          bitpos <= 4'd14;
          state <= N_SQT;
        end
        // square 2*trial-1, trial being q with the trial bit set
        N_SQT: begin
          tt <= sq;
          state <= N_CMP;
        end
        // binary search for the largest q with (2q-1)^2*s <= m^2*2^30
        N_CMP: begin
          if (bitpos == 4'd0) begin
            qres[comp] <= fit ? trial : q;
            if (comp == 2'd2) begin
              state <= N_DONE;
            end else begin
              comp <= comp + 2'd1;
              state <= N_LIM;
            end
          end else begin
            if (fit) q <= trial;
            bitpos <= bitpos - 4'd1;
            state <= N_SQT;
          end
        end
        N_DONE: begin
          qx <= sgn[0] ? -NormW'(qres[0]) : NormW'(qres[0]);
          qy <= sgn[1] ? -NormW'(qres[1]) : NormW'(qres[1]);
          qz <= sgn[2] ? -NormW'(qres[2]) : NormW'(qres[2]);
          done <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("normalizer done held");
  a_idle_done: assert property (@(posedge clk) disable iff (rst)
    done |-> state == N_IDLE)
    else $error("done outside idle");
  a_q_range: assert property (@(posedge clk) disable iff (rst)
    (state == N_CMP) |-> q <= 15'd16384)
    else $error("q out of range");

endmodule

// ===== rtl/core/vertex_normal_accumulator_unit.sv =====
// top level: vertex store, sum memories and operation sequencer
// A transfer is taken only when the unit is idle; each item occupies it until its
// result transfer completes, and the next item can be taken in the cycle after. After
// reset a clearing pass over all 1024 entries resets the loaded flags before the first
// transfer. A load or the reserved opcode goes straight to the result; an add triangle
// makes three position reads, six products on one multiplier and three
// read-modify-writes, and stops at the first corner that is not loaded; a read makes up
// to 32 shift steps, three squares and 45 search steps on one shared squarer, and ends
// early for a zero sum or an unloaded vertex.
module vertex_normal_accumulator_unit
  import vna_pkg::*;
(
  input logic clk,
  input logic rst,
  vna_req_if.sink   in_ch,
  vna_res_if.source out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RDP  = 4'd2;
  localparam logic [3:0] S_CAP  = 4'd3;
  localparam logic [3:0] S_CRS  = 4'd4;
  localparam logic [3:0] S_RDS  = 4'd5;
  localparam logic [3:0] S_WRS  = 4'd6;
  localparam logic [3:0] S_NRD  = 4'd7;
  localparam logic [3:0] S_NRM  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_CLR  = 4'd10;
  localparam logic [3:0] S_VCK  = 4'd11;

  logic [3:0] state;
  req_t req;
  res_t res;
  // position word: loaded flag over x, y, z
  logic [3*PosW:0] pos_mem [MaxVerts];
  logic [3*SumW-1:0] sum_mem [MaxVerts];
  logic [3*PosW:0] pos_q;
  logic [3*SumW-1:0] sum_q;
  logic [IdxW-1:0] p_addr, s_addr, clr_idx;
  logic [1:0] cnt;
  logic half;
  logic signed [PosW-1:0] pa [3];
  logic signed [PosW-1:0] pb [3];
  logic signed [PosW-1:0] pc [3];
  logic signed [34:0] nv [3];
  logic signed [SumW-1:0] upd [3];
  logic n_start, n_done;
  logic nzero;
  logic signed [NormW-1:0] qx, qy, qz;

  logic signed [16:0] u1, w1, u2, w2, mu, mw;
  logic signed [33:0] prod;

  // one cross-product term per cycle: indices rotate with cnt
  always_comb begin
    case (cnt)
      2'd0: begin
        u1 = 17'(pc[1]) - 17'(pa[1]); w1 = 17'(pb[2]) - 17'(pa[2]);
        u2 = 17'(pc[2]) - 17'(pa[2]); w2 = 17'(pb[1]) - 17'(pa[1]);
      end
      2'd1: begin
        u1 = 17'(pc[2]) - 17'(pa[2]); w1 = 17'(pb[0]) - 17'(pa[0]);
        u2 = 17'(pc[0]) - 17'(pa[0]); w2 = 17'(pb[2]) - 17'(pa[2]);
      end
      default: begin
        u1 = 17'(pc[0]) - 17'(pa[0]); w1 = 17'(pb[1]) - 17'(pa[1]);
        u2 = 17'(pc[1]) - 17'(pa[1]); w2 = 17'(pb[0]) - 17'(pa[0]);
      end
    endcase
    mu = half ? u2 : u1;
    mw = half ? w2 : w1;
    prod = 34'(mu) * 34'(mw);
  end

  // saturating add of the cross product into the sum word
  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] s,
                                                     logic signed [34:0] d);
    logic signed [SumW:0] r;
    r = (SumW+1)'(s) + (SumW+1)'(d);
    if (r > (SumW+1)'(SumMax)) return SumMax;
    if (r < (SumW+1)'(SumMin)) return SumMin;
    return r[SumW-1:0];
  endfunction

  always_comb begin
    upd[0] = sat_add(sum_q[3*SumW-1:2*SumW], nv[0]);
    upd[1] = sat_add(sum_q[2*SumW-1:SumW], nv[1]);
    upd[2] = sat_add(sum_q[SumW-1:0], nv[2]);
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    pos_q <= pos_mem[p_addr];
    sum_q <= sum_mem[s_addr];
    if (state == S_CLR) begin
      pos_mem[clr_idx] <= '0;
    end else if (state == S_DEC && req.opcode == OP_LOAD) begin
      pos_mem[req.vertex_index] <= {1'b1, req.pos_x, req.pos_y, req.pos_z};
    end
    if (state == S_DEC && req.opcode == OP_LOAD) begin
      sum_mem[req.vertex_index] <= '0;
    end else if (state == S_WRS) begin
      sum_mem[s_addr] <= {upd[0], upd[1], upd[2]};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
    end else begin
      case (state)
        // clear the loaded flags one entry a cycle
        S_CLR: begin
          clr_idx <= clr_idx + IdxW'(1);
          if (clr_idx == IdxW'(MaxVerts - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            req <= in_ch.data;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res <= '{norm_x: '0, norm_y: '0, norm_z: '0, status: ST_OK};
          cnt <= 2'd0;
          half <= 1'b0;
          case (req.opcode)
            OP_LOAD: state <= S_OUT;
            OP_ADD: begin
              p_addr <= req.corner_a;
              state <= S_RDP;
            end
            OP_READ: begin
              p_addr <= req.vertex_index;
              s_addr <= req.vertex_index;
              state <= S_NRD;
            end
            default: state <= S_OUT;
          endcase
        end
        S_RDP: state <= S_CAP;
        // capture corner positions one per pass, stop at an unloaded corner
        S_CAP: begin
          if (!pos_q[3*PosW]) begin
            res.status <= ST_UNLOAD;
            state <= S_OUT;
          end else begin
            case (cnt)
              2'd0: begin
                pa[0] <= pos_q[47:32]; pa[1] <= pos_q[31:16]; pa[2] <= pos_q[15:0];
                p_addr <= req.corner_b; cnt <= 2'd1; state <= S_RDP;
              end
              2'd1: begin
                pb[0] <= pos_q[47:32]; pb[1] <= pos_q[31:16]; pb[2] <= pos_q[15:0];
                p_addr <= req.corner_c; cnt <= 2'd2; state <= S_RDP;
              end
              default: begin
                pc[0] <= pos_q[47:32]; pc[1] <= pos_q[31:16]; pc[2] <= pos_q[15:0];
                cnt <= 2'd0; state <= S_CRS;
              end
            endcase
          end
        end
        // first product of a component, then subtract the second
        S_CRS: begin
          if (!half) begin
            nv[cnt] <= 35'(prod);
            half <= 1'b1;
          end else begin
            nv[cnt] <= nv[cnt] - 35'(prod);
            half <= 1'b0;
            if (cnt == 2'd2) begin
              cnt <= 2'd0;
              s_addr <= req.corner_a;
              state <= S_RDS;
            end else begin
              cnt <= cnt + 2'd1;
            end
          end
        end
        S_RDS: state <= S_WRS;
        // write back, then read the next corner (sees repeated corners updated)
        S_WRS: begin
          if (cnt == 2'd2) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt + 2'd1;
            s_addr <= (cnt == 2'd0) ? req.corner_b : req.corner_c;
            state <= S_RDS;
          end
        end
        S_NRD: state <= S_VCK;
        // loaded check; the normalizer starts here on the sum just read
        S_VCK: begin
          if (!pos_q[3*PosW]) begin
            res.status <= ST_UNLOAD;
            state <= S_OUT;
          end else begin
            state <= S_NRM;
          end
        end
        S_NRM: begin
          if (n_done) begin
            res <= '{norm_x: qx, norm_y: qy, norm_z: qz,
                     status: nzero ? ST_ZERO : ST_OK};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign n_start = (state == S_VCK) && pos_q[3*PosW];

  vna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .sx    (sum_q[3*SumW-1:2*SumW]),
    .sy    (sum_q[2*SumW-1:SumW]),
    .sz    (sum_q[SumW-1:0]),
    .done  (n_done),
    .zero  (nzero),
    .qx    (qx),
    .qy    (qy),
    .qz    (qz)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = res;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("accept during result");
  a_out_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && res.status != ST_OK |->
    res.norm_x == '0 && res.norm_y == '0 && res.norm_z == '0)
    else $error("nonzero norm with error status");
  a_nrm_done: assert property (@(posedge clk) disable iff (rst)
    n_done |-> state == S_NRM)
    else $error("normalizer done unexpected");

endmodule
